// ===== hdl/windowed_deviation_step_counter_macros.svh =====
// Assertion macros used by the step counter back end.
`ifndef WINDOWED_DEVIATION_STEP_COUNTER_MACROS_SVH
`define WINDOWED_DEVIATION_STEP_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define WDSC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wdsc: same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define WDSC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wdsc: next-cycle check failed");

`endif

// ===== hdl/wdsc_pkg.sv =====
// Shared types and constants for the windowed deviation step counter.
`default_nettype none

package wdsc_pkg;

    localparam int ACC_W      = 16;
    localparam int THR_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int SQ_W       = 32;            // x*x+y*y+z*z < 2^32
    localparam int ROOT_W     = SQ_W / 2;
    localparam int MAG_W      = 17;
    localparam int REM_W      = ROOT_W + 3;
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int Q_DEPTH    = 2;

    localparam logic [THR_W-1:0] READY_THR_RESET  = 16'd371;
    localparam logic [THR_W-1:0] RECORD_THR_RESET = 16'd358;

    // register select, from the word address bit
    localparam logic REG_READY  = 1'b0;
    localparam logic REG_RECORD = 1'b1;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
    } t_sample;

    typedef struct packed {
        logic [COUNT_W-1:0] step_count;
        logic               step_event;
        logic               ready_flag;
        logic               window_valid;
    } t_result;

    typedef struct packed {
        logic [SQ_W-1:0] sq;
        logic            window_valid;
    } t_job;

    typedef struct packed {
        logic [THR_W-1:0] ready_threshold;
        logic [THR_W-1:0] record_threshold;
    } t_cfg;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQ,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQRT,
        B_SUM,
        B_DEV,
        B_SQR,
        B_DSUM,
        B_LSQ,
        B_LIM,
        B_CMP
    } t_back_state;

endpackage

`default_nettype wire

// ===== hdl/wdsc_fifo.sv =====
// Two-entry queue used between front and back and on the result side.
`default_nettype none

module wdsc_fifo
    import wdsc_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (rd_en) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wdsc_front.sv =====
// Front end: takes a sample, sums the axis squares, tags warm-up, queues the job.
`default_nettype none

module wdsc_front
    import wdsc_pkg::*;
#(
    parameter int HALF_WINDOW = 15
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    output logic         o_full,
    input  wire t_sample i_sample,
    output logic         o_job_push,
    output t_job         o_job,
    input  wire logic    i_job_full
);

    localparam int VALID_FILL = 4 * HALF_WINDOW + 1;
    localparam int FILL_W     = $clog2(VALID_FILL + 1);

    t_front_state            r_state;
    t_front_state            n_state;
    t_sample                 r_smp;
    logic [AXIS_W-1:0]       r_axis;
    logic [SQ_W-1:0]         r_acc;
    logic [FILL_W-1:0]       r_fill;
    logic [FILL_W-1:0]       n_fill;
    logic                    r_valid;
    logic signed [ACC_W-1:0] axis_val;
    logic signed [2*ACC_W-1:0] axis_sq;
    logic                    accept;

    always_comb begin
        case (r_axis)
            AXIS_W'(0): axis_val = r_smp.accel_x;
            AXIS_W'(1): axis_val = r_smp.accel_y;
            default:    axis_val = r_smp.accel_z;
        endcase
    end

    assign axis_sq = (2*ACC_W)'(axis_val) * (2*ACC_W)'(axis_val);
    assign n_fill  = (r_fill == FILL_W'(VALID_FILL)) ? r_fill : r_fill + FILL_W'(1);

    always_comb begin
        n_state    = r_state;
        o_full     = 1'b1;
        o_job_push = 1'b0;
        accept     = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    accept  = 1'b1;
                    n_state = F_SQ;
                end
            end
            F_SQ: begin
                if (r_axis == AXIS_W'(NUM_AXES - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_job_push = !i_job_full;
                if (!i_job_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign o_job.sq           = r_acc;
    assign o_job.window_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_fill  <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_fill <= n_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_smp   <= i_sample;
            r_axis  <= '0;
            r_acc   <= '0;
            r_valid <= (n_fill == FILL_W'(VALID_FILL));
        end else if (r_state == F_SQ) begin
            r_axis <= r_axis + AXIS_W'(1);
            r_acc  <= r_acc + SQ_W'(unsigned'(axis_sq));
        end
    end

endmodule

`default_nettype wire

// ===== hdl/wdsc_back.sv =====
// Back end: square root, window sums, deviation, threshold hysteresis and step count.
`default_nettype none

`include "windowed_deviation_step_counter_macros.svh"

module wdsc_back
    import wdsc_pkg::*;
#(
    parameter int HALF_WINDOW = 15
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_job i_job,
    input  wire logic i_job_avail,
    output logic      o_job_pop,
    input  wire t_cfg i_cfg,
    input  wire logic i_out_full,
    output logic      o_res_push,
    output t_result   o_res
);

    localparam int N      = 2 * HALF_WINDOW + 1;
    localparam int NW     = $clog2(N + 1);
    localparam int POS_W  = $clog2(N);
    localparam int SUM_W  = MAG_W + NW;
    localparam int DSQ_W  = 2 * SUM_W;
    localparam int DSUM_W = DSQ_W + NW;
    localparam int N3     = N * N * N;
    localparam int N3_W   = $clog2(N3 + 1);
    localparam int LIM_W  = 2 * THR_W + N3_W;
    localparam int CMP_W  = (DSUM_W > LIM_W) ? DSUM_W : LIM_W;
    localparam int STEP_W = $clog2(SQRT_STEPS);

    t_back_state          r_state;
    t_back_state          n_state;
    logic [POS_W-1:0]     r_pos;
    logic [NW-1:0]        r_fill;
    logic [SQ_W-1:0]      r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [ROOT_W-1:0]    r_root;
    logic [STEP_W-1:0]    r_step;
    logic                 r_valid;
    logic [SUM_W-1:0]     r_msum;
    logic [SUM_W-1:0]     r_abs;
    logic [DSQ_W-1:0]     r_dsq;
    logic [DSUM_W-1:0]    r_dsum;
    logic [2*THR_W-1:0]   r_rdy_sq;
    logic [2*THR_W-1:0]   r_rec_sq;
    logic [LIM_W-1:0]     r_rdy_lim;
    logic [LIM_W-1:0]     r_rec_lim;
    logic                 r_ready;
    logic [COUNT_W-1:0]   r_steps;

    logic [MAG_W-1:0]     r_mag_line [N];
    logic [DSQ_W-1:0]     r_dsq_line [N];
    logic [MAG_W-1:0]     r_mag_cur_rd;
    logic [MAG_W-1:0]     r_mag_old_rd;
    logic [DSQ_W-1:0]     r_dsq_rd;

    logic [POS_W-1:0]     oldest;
    logic                 cur_written;
    logic                 old_written;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 take;
    logic [MAG_W-1:0]     mag;
    logic [MAG_W-1:0]     old_mag;
    logic [MAG_W-1:0]     start_mag;
    logic [SUM_W-1:0]     scaled;
    logic [DSQ_W-1:0]     old_dsq;
    logic [CMP_W-1:0]     dsum_c;
    logic                 above;
    logic                 below;
    logic                 step_evt;
    logic                 n_ready;
    logic [COUNT_W-1:0]   n_steps;

    assign oldest      = (r_pos == POS_W'(N - 1)) ? '0 : r_pos + POS_W'(1);
    // entries past the fill count were never written and read as zero
    assign cur_written = NW'(r_pos) < r_fill;
    assign old_written = NW'(oldest) < r_fill;

    // one result bit per step, restoring square root
    assign rem_sh = {r_rem[REM_W-3:0], r_rad[SQ_W-1 -: 2]};
    assign trial  = REM_W'({r_root, 2'b01});
    assign take   = rem_sh >= trial;

    assign mag       = MAG_W'(r_root);
    assign old_mag   = cur_written ? r_mag_cur_rd : '0;
    assign start_mag = old_written ? r_mag_old_rd : '0;
    assign scaled    = SUM_W'(start_mag) * SUM_W'(N);
    assign old_dsq   = cur_written ? r_dsq_rd : '0;

    assign dsum_c   = CMP_W'(r_dsum);
    assign above    = dsum_c > CMP_W'(r_rdy_lim);
    assign below    = dsum_c < CMP_W'(r_rec_lim);
    assign step_evt = r_valid && !above && below && r_ready;
    assign n_ready  = !r_valid ? r_ready : (above ? 1'b1 : (below ? 1'b0 : r_ready));
    assign n_steps  = (step_evt && (r_steps != '1)) ? r_steps + COUNT_W'(1) : r_steps;

    assign o_res.step_count   = n_steps;
    assign o_res.step_event   = step_evt;
    assign o_res.ready_flag   = n_ready;
    assign o_res.window_valid = r_valid;

    always_comb begin
        n_state    = r_state;
        o_job_pop  = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            B_IDLE: begin
                // only this unit fills the result queue, so room now is room at the end
                if (i_job_avail && !i_out_full) begin
                    o_job_pop = 1'b1;
                    n_state   = B_SQRT;
                end
            end
            B_SQRT: begin
                if (r_step == STEP_W'(SQRT_STEPS - 1)) begin
                    n_state = B_SUM;
                end
            end
            B_SUM:  n_state = B_DEV;
            B_DEV:  n_state = B_SQR;
            B_SQR:  n_state = B_DSUM;
            B_DSUM: n_state = B_LSQ;
            B_LSQ:  n_state = B_LIM;
            B_LIM:  n_state = B_CMP;
            B_CMP: begin
                o_res_push = 1'b1;
                n_state    = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pos   <= '0;
            r_fill  <= '0;
            r_msum  <= '0;
            r_dsum  <= '0;
            r_ready <= 1'b0;
            r_steps <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                B_SUM:  r_msum <= r_msum - SUM_W'(old_mag) + SUM_W'(mag);
                B_DSUM: r_dsum <= r_dsum - DSUM_W'(old_dsq) + DSUM_W'(r_dsq);
                B_CMP: begin
                    r_ready <= n_ready;
                    r_steps <= n_steps;
                    r_pos   <= oldest;
                    if (r_fill != NW'(N)) begin
                        r_fill <= r_fill + NW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_rad   <= i_job.sq;
                r_valid <= i_job.window_valid;
                r_rem   <= '0;
                r_root  <= '0;
                r_step  <= '0;
            end
            B_SQRT: begin
                r_rad  <= {r_rad[SQ_W-3:0], 2'b00};
                r_rem  <= take ? rem_sh - trial : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
                r_step <= r_step + STEP_W'(1);
            end
            B_DEV: r_abs <= (scaled >= r_msum) ? scaled - r_msum : r_msum - scaled;
            B_SQR: r_dsq <= DSQ_W'(r_abs) * DSQ_W'(r_abs);
            B_LSQ: begin
                r_rdy_sq <= (2*THR_W)'(i_cfg.ready_threshold) * (2*THR_W)'(i_cfg.ready_threshold);
                r_rec_sq <= (2*THR_W)'(i_cfg.record_threshold)
                            * (2*THR_W)'(i_cfg.record_threshold);
            end
            B_LIM: begin
                r_rdy_lim <= LIM_W'(r_rdy_sq) * LIM_W'(N3);
                r_rec_lim <= LIM_W'(r_rec_sq) * LIM_W'(N3);
            end
            default: ;
        endcase
    end

    // window lines: one write each; two registered reads of the magnitude line, one of the square line
    always_ff @(posedge i_clk) begin
        if (r_state == B_SUM) begin
            r_mag_line[r_pos] <= mag;
        end
        if (r_state == B_DSUM) begin
            r_dsq_line[r_pos] <= r_dsq;
        end
        r_mag_cur_rd <= r_mag_line[r_pos];
        r_mag_old_rd <= r_mag_line[oldest];
        r_dsq_rd     <= r_dsq_line[r_pos];
    end

    `WDSC_ASSERT_IMP(a_event_needs_window, o_res_push && o_res.step_event, o_res.window_valid)
    `WDSC_ASSERT_IMP(a_result_has_room, o_res_push, !i_out_full)
    `WDSC_ASSERT_NXT(a_steps_only_at_compare, i_rst_n && (r_state != B_CMP), $stable(r_steps))
    `WDSC_ASSERT_NXT(a_step_clears_ready, (r_state == B_CMP) && step_evt, !r_ready)

endmodule

`default_nettype wire

// ===== hdl/windowed_deviation_step_counter.sv =====
// Top level of the windowed deviation step counter.
//
// Usage:
//   Samples enter on a queue-style port: push with i_sample, taken when full is low.
//   Results leave the same way: while empty is low, o_result holds the oldest
//   result and pop takes it. Each sample gives exactly one result beat.
//   Thresholds are written over APB (ready level at 0x0, record level at 0x4), by the
//   user only while no sample is in flight (not enforced here); pready is tied high.
// Timing:
//   A sample is squared and summed by the front end, queued, and run through the
//   back end's bit-per-cycle square root, window sums, deviation, limits and
//   compare into the result queue. The back end sets the sustained rate: it takes
//   a new job only once the last result is pushed; front runs up to two jobs ahead.
// Reset:
//   Synchronous, active low. Window sums, step count and hysteresis clear, the
//   thresholds return to 371 and 358, and the window lines read as zero until
//   written. window_valid rises once 4*HALF_WINDOW+1 samples have been seen.
// Stalls:
//   Two results queue at the output; once they are not taken the back end holds
//   its next job, the middle queue fills and full rises. Nothing is dropped.
`default_nettype none

module windowed_deviation_step_counter
    import wdsc_pkg::*;
#(
    parameter int HALF_WINDOW = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_sample     i_sample,
    output logic             empty,
    input  wire logic        pop,
    output t_result          o_result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int JOB_W = $bits(t_job);
    localparam int RES_W = $bits(t_result);

    logic [THR_W-1:0] r_ready_thr;
    logic [THR_W-1:0] r_record_thr;
    t_cfg             cfg;
    logic             cfg_wr;

    logic             job_push;
    t_job             job_in;
    logic             job_full;
    logic             job_pop;
    logic [JOB_W-1:0] job_bits;
    logic             job_empty;
    logic             res_push;
    t_result          res_in;
    logic             res_full;
    logic [RES_W-1:0] res_bits;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready_thr  <= READY_THR_RESET;
            r_record_thr <= RECORD_THR_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_READY:  r_ready_thr  <= pwdata[THR_W-1:0];
                REG_RECORD: r_record_thr <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_READY:  prdata = 32'(r_ready_thr);
            REG_RECORD: prdata = 32'(r_record_thr);
            default:    prdata = '0;
        endcase
    end

    assign cfg.ready_threshold  = r_ready_thr;
    assign cfg.record_threshold = r_record_thr;

    wdsc_front #(
        .HALF_WINDOW(HALF_WINDOW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_sample  (i_sample),
        .o_job_push(job_push),
        .o_job     (job_in),
        .i_job_full(job_full)
    );

    wdsc_fifo #(
        .WIDTH(JOB_W)
    ) u_job_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_data (job_in),
        .o_full (job_full),
        .i_pop  (job_pop),
        .o_data (job_bits),
        .o_empty(job_empty)
    );

    wdsc_back #(
        .HALF_WINDOW(HALF_WINDOW)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (t_job'(job_bits)),
        .i_job_avail(!job_empty),
        .o_job_pop  (job_pop),
        .i_cfg      (cfg),
        .i_out_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    wdsc_fifo #(
        .WIDTH(RES_W)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (res_push),
        .i_data (res_in),
        .o_full (res_full),
        .i_pop  (pop),
        .o_data (res_bits),
        .o_empty(empty)
    );

    assign o_result = t_result'(res_bits);

endmodule

`default_nettype wire
